### rtl/ssp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shortest-path block.
// No dependencies; every other file refers to it by scoped name.

package ssp_pkg;

   // Default sizes, handed to the top-level parameters
   localparam int NODES_DEF       = 16;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int DIST_BITS_DEF   = 24;

   // Fixed port field widths
   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 24;
   localparam int COUNT_W  = 7;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd16;

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_RUN   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_RELAX,
      ST_DRAIN,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } wmem_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clear;
   } dmem_ctl_type;

endpackage

### rtl/ssp_wmem.sv
`timescale 1ns / 1ps
// Adjacency matrix store: one write port, one registered read port.
// Uses ssp_pkg for the control struct.

module ssp_wmem #(
   parameter int NODES       = ssp_pkg::NODES_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                 clock,
   input  ssp_pkg::wmem_ctl_type                ctl,
   input  logic [$clog2(NODES*NODES)-1:0]       wr_addr,
   input  logic [WEIGHT_BITS-1:0]               wr_data,
   input  logic [$clog2(NODES*NODES)-1:0]       rd_addr,
   output logic [WEIGHT_BITS-1:0]               rd_data
);

   localparam int DEPTH = NODES * NODES;

   logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
   logic [WEIGHT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= weight_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ssp_dmem.sv
`timescale 1ns / 1ps
// Best-distance store with per-entry valid bits; an invalid entry reads all ones.
// Uses ssp_pkg for the control struct.

module ssp_dmem #(
   parameter int NODES     = ssp_pkg::NODES_DEF,
   parameter int DIST_BITS = ssp_pkg::DIST_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ssp_pkg::dmem_ctl_type        ctl,
   input  logic [$clog2(NODES)-1:0]     wr_addr,
   input  logic [DIST_BITS-1:0]         wr_data,
   input  logic [$clog2(NODES)-1:0]     rd_addr,
   output logic [DIST_BITS-1:0]         rd_data
);

   logic [DIST_BITS-1:0] dist_mem [NODES];
   logic [DIST_BITS-1:0] rd_data_ff;
   logic [NODES-1:0]     vld_ff;
   logic [NODES-1:0]     vld_in;
   logic                 rd_vld_ff;
   logic                 rd_vld_in;

   always_comb begin
      vld_in    = vld_ff;
      rd_vld_in = rd_vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end
      if (ctl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (ctl.rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         dist_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= dist_mem[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '1;

endmodule

### rtl/ssp_ctrl.sv
`timescale 1ns / 1ps
// Run sequencer: edge writes, relaxation pipeline, nearest-node selection
// and result output. Uses ssp_pkg; drives ssp_wmem and ssp_dmem.

module ssp_ctrl #(
   parameter int NODES       = ssp_pkg::NODES_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = ssp_pkg::DIST_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ssp_pkg::COUNT_W-1:0]           csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [ssp_pkg::NODE_W-1:0]            req_from_node,
   input  logic [ssp_pkg::NODE_W-1:0]            req_to_node,
   input  logic [ssp_pkg::WEIGHT_W-1:0]          req_edge_weight,
   input  logic [ssp_pkg::NODE_W-1:0]            req_start_node,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ssp_pkg::NODE_W-1:0]            rsp_node,
   output logic [ssp_pkg::DIST_W-1:0]            rsp_distance,
   output logic                                  rsp_last,
   output ssp_pkg::wmem_ctl_type                 wmem_ctl,
   output logic [$clog2(NODES*NODES)-1:0]        wmem_wr_addr,
   output logic [WEIGHT_BITS-1:0]                wmem_wr_data,
   output logic [$clog2(NODES*NODES)-1:0]        wmem_rd_addr,
   input  logic [WEIGHT_BITS-1:0]                wmem_rd_data,
   output ssp_pkg::dmem_ctl_type                 dmem_ctl,
   output logic [$clog2(NODES)-1:0]              dmem_wr_addr,
   output logic [DIST_BITS-1:0]                  dmem_wr_data,
   output logic [$clog2(NODES)-1:0]              dmem_rd_addr,
   input  logic [DIST_BITS-1:0]                  dmem_rd_data
);

   localparam int NODE_BITS = $clog2(NODES);
   localparam int ADDR_BITS = $clog2(NODES * NODES);
   localparam int SUM_BITS  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam int COUNT_W   = ssp_pkg::COUNT_W;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   ssp_pkg::state_type state_ff, state_in;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [NODE_BITS-1:0] nodes_m1_ff, nodes_m1_in;
   logic [ssp_pkg::NODE_W-1:0] start_ff, start_in;
   logic [NODE_BITS-1:0] idx_ff, idx_in;
   logic [NODE_BITS-1:0] pick_ff, pick_in;
   logic [DIST_BITS-1:0] pick_dist_ff, pick_dist_in;
   logic [NODES-1:0]     fin_ff, fin_in;

   logic                 s2_vld_ff, s2_vld_in;
   logic                 s2_last_ff, s2_last_in;
   logic [NODE_BITS-1:0] s2_idx_ff, s2_idx_in;
   logic                 s3_vld_ff, s3_vld_in;
   logic                 s3_last_ff, s3_last_in;
   logic [NODE_BITS-1:0] s3_idx_ff, s3_idx_in;
   logic [DIST_BITS-1:0] s3_sum_ff, s3_sum_in;
   logic [DIST_BITS-1:0] s3_old_ff, s3_old_in;

   logic                 min_found_ff, min_found_in;
   logic [NODE_BITS-1:0] min_idx_ff, min_idx_in;
   logic [DIST_BITS-1:0] min_val_ff, min_val_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ssp_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [ssp_pkg::DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]                     used_m1;
   logic                                   start_ok;
   logic                                   write_ok;
   logic [SUM_BITS-1:0]                    sum_raw;
   logic [WEIGHT_BITS+ssp_pkg::WEIGHT_W-1:0] weight_wide;
   logic [DIST_BITS+ssp_pkg::DIST_W-1:0]   dist_wide;
   logic                                   cand_lt_old;
   logic                                   cand_lt_min;
   logic                                   old_lt_min;
   logic                                   better;

   // Clamp the node count into 1..NODES, kept as count minus one
   assign used_m1 = (count_ff == '0) ? '0 :
                    (count_ff > COUNT_W'(NODES)) ? COUNT_W'(NODES - 1) :
                    count_ff - COUNT_W'(1);

   assign start_ok = COUNT_W'(start_ff) <= COUNT_W'(nodes_m1_ff);
   assign write_ok = (COUNT_W'(req_from_node) < COUNT_W'(NODES)) &&
                     (COUNT_W'(req_to_node) < COUNT_W'(NODES));

   assign weight_wide  = {{WEIGHT_BITS{1'b0}}, req_edge_weight};
   assign wmem_wr_data = weight_wide[WEIGHT_BITS-1:0];
   assign wmem_wr_addr = ADDR_BITS'(req_from_node[NODE_BITS-1:0]) * ADDR_BITS'(NODES) +
                         ADDR_BITS'(req_to_node[NODE_BITS-1:0]);
   assign wmem_rd_addr = ADDR_BITS'(pick_ff) * ADDR_BITS'(NODES) + ADDR_BITS'(idx_ff);
   assign dmem_rd_addr = idx_ff;

   assign dist_wide = {{ssp_pkg::DIST_W{1'b0}}, dmem_rd_data};

   // Saturating path sum through the current pick
   assign sum_raw = SUM_BITS'(pick_dist_ff) + SUM_BITS'(wmem_rd_data);

   assign cand_lt_old = s3_sum_ff < s3_old_ff;
   assign cand_lt_min = s3_sum_ff < min_val_ff;
   assign old_lt_min  = s3_old_ff < min_val_ff;
   assign better      = !min_found_ff || (cand_lt_old ? cand_lt_min : old_lt_min);

   always_comb begin
      state_in        = state_ff;
      count_in        = csr_wr_en ? csr_wr_data : count_ff;
      nodes_m1_in     = nodes_m1_ff;
      start_in        = start_ff;
      idx_in          = idx_ff;
      pick_in         = pick_ff;
      pick_dist_in    = pick_dist_ff;
      fin_in          = fin_ff;
      min_found_in    = min_found_ff;
      min_idx_in      = min_idx_ff;
      min_val_in      = min_val_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_node_in     = rsp_node_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_last_in     = rsp_last_ff;
      req_ready       = 1'b0;
      wmem_ctl        = '0;
      dmem_ctl        = '0;
      dmem_wr_addr    = s3_idx_ff;
      dmem_wr_data    = s3_sum_ff;

      // Second stage: weight and old distance arrive, form the candidate
      s2_vld_in  = 1'b0;
      s2_last_in = 1'b0;
      s2_idx_in  = s2_idx_ff;
      s3_vld_in  = s2_vld_ff;
      s3_last_in = s2_last_ff;
      s3_idx_in  = s2_idx_ff;
      s3_old_in  = dmem_rd_data;
      s3_sum_in  = (sum_raw > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum_raw[DIST_BITS-1:0];

      // Third stage: write back a shorter distance and track the nearest
      // unfinished node. Reads lead this write by two entries, so no
      // forwarding is needed.
      if (s3_vld_ff) begin
         if (cand_lt_old) begin
            dmem_ctl.wr_en = 1'b1;
         end
         if (!fin_ff[s3_idx_ff] && better) begin
            min_found_in = 1'b1;
            min_idx_in   = s3_idx_ff;
            min_val_in   = cand_lt_old ? s3_sum_ff : s3_old_ff;
         end
      end

      case (state_ff)
         ssp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == ssp_pkg::FUNC_RUN) begin
                  nodes_m1_in = used_m1[NODE_BITS-1:0];
                  start_in    = req_start_node;
                  state_in    = ssp_pkg::ST_INIT;
               end else if (write_ok) begin
                  wmem_ctl.wr_en = 1'b1;
               end
            end
         end
         ssp_pkg::ST_INIT: begin
            dmem_ctl.clear = 1'b1;
            fin_in         = '0;
            idx_in         = '0;
            min_found_in   = 1'b0;
            if (start_ok) begin
               dmem_ctl.wr_en = 1'b1;
               dmem_wr_addr   = start_ff[NODE_BITS-1:0];
               dmem_wr_data   = '0;
               fin_in[start_ff[NODE_BITS-1:0]] = 1'b1;
               pick_in        = start_ff[NODE_BITS-1:0];
               pick_dist_in   = '0;
               state_in       = ssp_pkg::ST_RELAX;
            end else begin
               state_in = ssp_pkg::ST_OUT_RD;
            end
         end
         ssp_pkg::ST_RELAX: begin
            wmem_ctl.rd_en = 1'b1;
            dmem_ctl.rd_en = 1'b1;
            s2_vld_in      = 1'b1;
            s2_idx_in      = idx_ff;
            s2_last_in     = idx_ff == nodes_m1_ff;
            if (idx_ff == nodes_m1_ff) begin
               state_in = ssp_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + NODE_BITS'(1);
            end
         end
         ssp_pkg::ST_DRAIN: begin
            if (s3_vld_ff && s3_last_ff) begin
               idx_in = '0;
               // Stop once nothing unfinished is reachable
               if (min_found_in && min_val_in != DIST_MAX) begin
                  pick_in            = min_idx_in;
                  pick_dist_in       = min_val_in;
                  fin_in[min_idx_in] = 1'b1;
                  min_found_in       = 1'b0;
                  state_in           = ssp_pkg::ST_RELAX;
               end else begin
                  state_in = ssp_pkg::ST_OUT_RD;
               end
            end
         end
         ssp_pkg::ST_OUT_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dmem_ctl.rd_en = 1'b1;
               state_in       = ssp_pkg::ST_OUT_LD;
            end
         end
         ssp_pkg::ST_OUT_LD: begin
            rsp_valid_in    = 1'b1;
            rsp_node_in     = ssp_pkg::NODE_W'(idx_ff);
            rsp_distance_in = dist_wide[ssp_pkg::DIST_W-1:0];
            rsp_last_in     = idx_ff == nodes_m1_ff;
            if (idx_ff == nodes_m1_ff) begin
               state_in = ssp_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + NODE_BITS'(1);
               state_in = ssp_pkg::ST_OUT_RD;
            end
         end
         default: begin
            state_in = ssp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssp_pkg::ST_IDLE;
         count_ff     <= ssp_pkg::COUNT_RESET;
         fin_ff       <= '0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         min_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         min_found_ff <= min_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nodes_m1_ff     <= nodes_m1_in;
      start_ff        <= start_in;
      idx_ff          <= idx_in;
      pick_ff         <= pick_in;
      pick_dist_ff    <= pick_dist_in;
      s2_last_ff      <= s2_last_in;
      s2_idx_ff       <= s2_idx_in;
      s3_last_ff      <= s3_last_in;
      s3_idx_ff       <= s3_idx_in;
      s3_sum_ff       <= s3_sum_in;
      s3_old_ff       <= s3_old_in;
      min_idx_ff      <= min_idx_in;
      min_val_ff      <= min_val_in;
      rsp_node_ff     <= rsp_node_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_node     = rsp_node_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/single_source_shortest_paths.sv
`timescale 1ns / 1ps
// Shortest distances over a stored adjacency matrix.
// A run over n nodes does r <= n rounds of relaxation, each reading one matrix row at
// one entry a cycle, then reads out one result per node, each held until taken.
// The next request is taken while the last result still waits.
// Synchronous reset clears control state and sets the node count to 16; matrix
// contents stay undefined until written.

module single_source_shortest_paths #(
   parameter int NODES       = ssp_pkg::NODES_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF,
   parameter int DIST_BITS   = ssp_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ssp_pkg::COUNT_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [ssp_pkg::NODE_W-1:0]    req_from_node,
   input  logic [ssp_pkg::NODE_W-1:0]    req_to_node,
   input  logic [ssp_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  logic [ssp_pkg::NODE_W-1:0]    req_start_node,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ssp_pkg::NODE_W-1:0]    rsp_node,
   output logic [ssp_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_last
);

   localparam int NODE_BITS = $clog2(NODES);
   localparam int ADDR_BITS = $clog2(NODES * NODES);

   ssp_pkg::wmem_ctl_type  wmem_ctl;
   logic [ADDR_BITS-1:0]   wmem_wr_addr;
   logic [WEIGHT_BITS-1:0] wmem_wr_data;
   logic [ADDR_BITS-1:0]   wmem_rd_addr;
   logic [WEIGHT_BITS-1:0] wmem_rd_data;
   ssp_pkg::dmem_ctl_type  dmem_ctl;
   logic [NODE_BITS-1:0]   dmem_wr_addr;
   logic [DIST_BITS-1:0]   dmem_wr_data;
   logic [NODE_BITS-1:0]   dmem_rd_addr;
   logic [DIST_BITS-1:0]   dmem_rd_data;

   ssp_ctrl #(
      .NODES       (NODES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .DIST_BITS   (DIST_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_from_node   (req_from_node),
      .req_to_node     (req_to_node),
      .req_edge_weight (req_edge_weight),
      .req_start_node  (req_start_node),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_node        (rsp_node),
      .rsp_distance    (rsp_distance),
      .rsp_last        (rsp_last),
      .wmem_ctl        (wmem_ctl),
      .wmem_wr_addr    (wmem_wr_addr),
      .wmem_wr_data    (wmem_wr_data),
      .wmem_rd_addr    (wmem_rd_addr),
      .wmem_rd_data    (wmem_rd_data),
      .dmem_ctl        (dmem_ctl),
      .dmem_wr_addr    (dmem_wr_addr),
      .dmem_wr_data    (dmem_wr_data),
      .dmem_rd_addr    (dmem_rd_addr),
      .dmem_rd_data    (dmem_rd_data)
   );

   ssp_wmem #(
      .NODES       (NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_wmem (
      .clock   (clock),
      .ctl     (wmem_ctl),
      .wr_addr (wmem_wr_addr),
      .wr_data (wmem_wr_data),
      .rd_addr (wmem_rd_addr),
      .rd_data (wmem_rd_data)
   );

   ssp_dmem #(
      .NODES     (NODES),
      .DIST_BITS (DIST_BITS)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dmem_ctl),
      .wr_addr (dmem_wr_addr),
      .wr_data (dmem_wr_data),
      .rd_addr (dmem_rd_addr),
      .rd_data (dmem_rd_data)
   );

endmodule
